// ===== hdl/isort_pkg.sv =====
package isort_pkg;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_run;
        logic               dropped;
    } out_item_t;

    // Load-side command to the sort core
    typedef struct packed {
        logic        wr;
        logic [6:0]  addr;
        logic [31:0] data;
        logic        last;
        logic        drop;
    } cmd_t;

    localparam int StackDepth = 16;

    function automatic logic [3:0] depth_lookup(input logic [6:0] n);
        logic [3:0] d;
        begin
            if (n < 7'd2)       d = 4'd0;
            else if (n < 7'd3)  d = 4'd1;
            else if (n < 7'd5)  d = 4'd2;
            else if (n < 7'd8)  d = 4'd3;
            else if (n < 7'd13) d = 4'd4;
            else if (n < 7'd21) d = 4'd5;
            else if (n < 7'd34) d = 4'd6;
            else if (n < 7'd55) d = 4'd7;
            else                d = 4'd8;
            return d;
        end
    endfunction

endpackage

// ===== hdl/isort_front.sv =====
module isort_front #(
    parameter int MAX_ITEMS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  isort_pkg::in_item_t in_item,
    input  logic              in_valid,
    output logic              in_stall,
    output isort_pkg::cmd_t   q_data,
    output logic              q_valid,
    input  logic              q_stall
);
    import isort_pkg::*;

    logic [6:0] count_reg, count_next;
    logic       ovf_reg, ovf_next;
    cmd_t       cmd_reg, cmd_next;
    logic       cv_reg, cv_next;
    logic       take;

    assign in_stall = cv_reg && q_stall;
    assign take     = in_valid && !in_stall;
    assign q_data   = cmd_reg;
    assign q_valid  = cv_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        cmd_next   = cmd_reg;
        cv_next    = cv_reg && q_stall;
        if (take)
        begin
            cv_next       = 1'b1;
            cmd_next.addr = count_reg;
            cmd_next.data = in_item.value;
            cmd_next.last = in_item.last;
            cmd_next.wr   = (count_reg < 7'(MAX_ITEMS));
            cmd_next.drop = ovf_reg || (count_reg >= 7'(MAX_ITEMS));
            if (count_reg < 7'(MAX_ITEMS))
                count_next = count_reg + 7'd1;
            else
                ovf_next = 1'b1;
            if (in_item.last)
            begin
                count_next = 7'd0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 7'd0;
            ovf_reg   <= 1'b0;
            cv_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            cv_reg    <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== hdl/isort_core.sv =====
module isort_core #(
    parameter int MAX_ITEMS         = 64,
    parameter int SMALL_RANGE_LIMIT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isort_pkg::cmd_t      q_data,
    input  logic                 q_valid,
    output logic                 q_stall,
    output isort_pkg::out_item_t out_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 busy
);
    import isort_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_POP   = 5'd1;
    localparam logic [4:0] S_RDA   = 5'd2;
    localparam logic [4:0] S_RDB   = 5'd3;
    localparam logic [4:0] S_WR    = 5'd4;
    localparam logic [4:0] S_DISP  = 5'd5;
    localparam logic [4:0] S_INSO  = 5'd6;
    localparam logic [4:0] S_INSI  = 5'd7;
    localparam logic [4:0] S_MED   = 5'd8;
    localparam logic [4:0] S_PSET  = 5'd9;
    localparam logic [4:0] S_PLOOP = 5'd10;
    localparam logic [4:0] S_PEND  = 5'd11;
    localparam logic [4:0] S_HUP   = 5'd12;
    localparam logic [4:0] S_HUPC  = 5'd13;
    localparam logic [4:0] S_HDN   = 5'd14;
    localparam logic [4:0] S_HDNI  = 5'd15;
    localparam logic [4:0] S_HDNC  = 5'd16;
    localparam logic [4:0] S_HCMP  = 5'd17;
    localparam logic [4:0] S_EMIT  = 5'd18;
    localparam logic [4:0] S_EWAIT = 5'd19;
    localparam logic [4:0] S_PUSH2 = 5'd20;
    localparam logic [4:0] S_INSW  = 5'd21;
    localparam logic [4:0] S_MED2  = 5'd22;
    localparam logic [4:0] S_HSEL  = 5'd23;

    // element memory, one write port and one read port: read registered
    logic signed [31:0] mem [MAX_ITEMS];
    logic signed [31:0] rd_reg;
    logic [AW-1:0]      ra;
    logic               we;
    logic [AW-1:0]      wa;
    logic signed [31:0] wd;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_reg <= mem[ra];
    end

    logic [17:0] stk [StackDepth];
    logic        sp_we;
    logic [3:0]  sp_wa;
    logic [17:0] sp_wd;

    always_ff @(posedge clk)
    begin
        if (sp_we)
            stk[sp_wa] <= sp_wd;
    end

    logic [4:0]  st_reg, st_next, ret_reg, ret_next;
    logic [4:0]  sp_reg, sp_next;
    logic [6:0]  n_reg, n_next;
    logic        drop_reg, drop_next;
    logic [6:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [3:0]  dp_reg, dp_next;
    logic [6:0]  i_reg, i_next, j_reg, j_next, p_reg, p_next, k_reg, k_next;
    logic [6:0]  a_reg, a_next, b_reg, b_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next, v_reg, v_next;
    logic [1:0]  mc_reg, mc_next;
    logic [6:0]  m_reg, m_next;
    logic signed [31:0] e0_reg, e0_next, e1_reg, e1_next;
    logic [6:0]  hn_reg, hn_next;
    out_item_t   ob_reg, ob_next;
    logic        ov_reg, ov_next;
    logic [17:0] top;
    logic [6:0]  mid;

    assign top       = stk[sp_reg[3:0] - 4'd1];
    assign mid       = 7'((8'(lo_reg) + 8'(hi_reg)) >> 1);
    assign q_stall   = (st_reg != S_LOAD);
    assign out_item  = ob_reg;
    assign out_valid = ov_reg;
    assign busy      = (st_reg != S_LOAD) || ov_reg;

    always_comb
    begin
        st_next = st_reg; ret_next = ret_reg; sp_next = sp_reg;
        n_next = n_reg; drop_next = drop_reg;
        lo_next = lo_reg; hi_next = hi_reg; dp_next = dp_reg;
        i_next = i_reg; j_next = j_reg; p_next = p_reg; k_next = k_reg;
        a_next = a_reg; b_next = b_reg;
        x_next = x_reg; y_next = y_reg; v_next = v_reg;
        mc_next = mc_reg; m_next = m_reg; e0_next = e0_reg; e1_next = e1_reg;
        hn_next = hn_reg;
        ob_next = ob_reg; ov_next = ov_reg && out_stall;
        ra = '0; we = 1'b0; wa = '0; wd = '0;
        sp_we = 1'b0; sp_wa = '0; sp_wd = '0;
        unique case (st_reg)
            S_LOAD:
            begin
                if (q_valid)
                begin
                    we = q_data.wr;
                    wa = q_data.addr[AW-1:0];
                    wd = q_data.data;
                    if (q_data.last)
                    begin
                        n_next    = q_data.wr ? q_data.addr + 7'd1 : q_data.addr;
                        drop_next = q_data.drop;
                        sp_next   = 5'd0;
                        if (n_next > 7'd1)
                        begin
                            sp_we   = 1'b1;
                            sp_wa   = 4'd0;
                            sp_wd   = {depth_lookup(n_next), n_next, 7'd0};
                            sp_next = 5'd1;
                        end
                        k_next  = 7'd0;
                        st_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == 5'd0)
                begin
                    st_next = S_EMIT;
                    ra      = k_reg[AW-1:0];
                end
                else
                begin
                    sp_next = sp_reg - 5'd1;
                    lo_next = top[6:0];
                    hi_next = top[13:7];
                    dp_next = top[17:14];
                    st_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (hi_reg > n_reg || hi_reg <= lo_reg + 7'd1)
                    st_next = S_POP;
                else if (hi_reg - lo_reg < 7'(SMALL_RANGE_LIMIT))
                begin
                    i_next  = lo_reg + 7'd1;
                    st_next = S_INSO;
                end
                else if (dp_reg == 4'd0)
                begin
                    hn_next = hi_reg - lo_reg;
                    i_next  = 7'd1;
                    st_next = S_HUP;
                end
                else
                begin
                    mc_next = 2'd0;
                    ra      = lo_reg[AW-1:0];
                    st_next = S_MED;
                end
            end
            // swap a,b: read a, read b, write both; return to ret
            S_RDA:
            begin
                x_next  = rd_reg;
                ra      = b_reg[AW-1:0];
                st_next = S_RDB;
            end
            S_RDB:
            begin
                y_next  = rd_reg;
                we      = 1'b1;
                wa      = a_reg[AW-1:0];
                wd      = rd_reg;
                st_next = S_WR;
            end
            S_WR:
            begin
                we      = 1'b1;
                wa      = b_reg[AW-1:0];
                wd      = x_reg;
                st_next = ret_reg;
            end
            // insertion sort
            S_INSO:
            begin
                if (i_reg >= hi_reg)
                    st_next = S_POP;
                else
                begin
                    ra      = i_reg[AW-1:0];
                    st_next = S_INSW;
                end
            end
            S_INSW:
            begin
                v_next  = rd_reg;
                j_next  = i_reg;
                ra      = AW'(i_reg - 7'd1);
                st_next = S_INSI;
            end
            S_INSI:
            begin
                if (j_reg > lo_reg && rd_reg > v_reg)
                begin
                    we     = 1'b1;
                    wa     = j_reg[AW-1:0];
                    wd     = rd_reg;
                    j_next = j_reg - 7'd1;
                    ra     = AW'(j_reg - 7'd2);
                end
                else
                begin
                    we      = 1'b1;
                    wa      = j_reg[AW-1:0];
                    wd      = v_reg;
                    i_next  = i_reg + 7'd1;
                    st_next = S_INSO;
                end
            end
            // median of three: read lo, mid, hi-1
            S_MED:
            begin
                mc_next = mc_reg + 2'd1;
                if (mc_reg == 2'd0)
                begin
                    ra     = mid[AW-1:0];
                    e0_next = 32'sd0;
                end
                else if (mc_reg == 2'd1)
                begin
                    e0_next = rd_reg;
                    ra      = AW'(hi_reg - 7'd1);
                end
                else
                begin
                    e1_next = rd_reg;
                    st_next = S_MED2;
                end
                if (mc_reg == 2'd0)
                    x_next = rd_reg;
            end
            S_MED2:
            begin
                if (x_reg <= e0_reg && e0_reg <= e1_reg)        m_next = mid;
                else if (x_reg <= e1_reg && e1_reg <= e0_reg)   m_next = hi_reg - 7'd1;
                else if (e0_reg <= x_reg && x_reg <= e1_reg)    m_next = lo_reg;
                else if (e0_reg <= e1_reg && e1_reg <= x_reg)   m_next = hi_reg - 7'd1;
                else if (e1_reg <= x_reg && x_reg <= e0_reg)    m_next = lo_reg;
                else                                            m_next = mid;
                a_next   = m_next;
                b_next   = hi_reg - 7'd1;
                ra       = m_next[AW-1:0];
                ret_next = S_PSET;
                st_next  = S_RDA;
            end
            S_PSET:
            begin
                v_next  = x_reg;
                p_next  = lo_reg;
                i_next  = lo_reg;
                st_next = S_PLOOP;
            end
            S_PLOOP:
            begin
                if (i_reg >= hi_reg - 7'd1)
                begin
                    a_next   = p_reg;
                    b_next   = hi_reg - 7'd1;
                    ra       = p_reg[AW-1:0];
                    ret_next = S_PEND;
                    st_next  = S_RDA;
                end
                else
                begin
                    ra      = i_reg[AW-1:0];
                    st_next = S_PUSH2;
                end
            end
            S_PUSH2:
            begin
                i_next = i_reg + 7'd1;
                if (rd_reg < v_reg)
                begin
                    a_next   = p_reg;
                    b_next   = i_reg;
                    p_next   = p_reg + 7'd1;
                    ra       = p_reg[AW-1:0];
                    ret_next = S_PLOOP;
                    st_next  = S_RDA;
                end
                else
                    st_next = S_PLOOP;
            end
            S_PEND:
            begin
                sp_next = sp_reg;
                if (hi_reg > p_reg + 7'd2)
                begin
                    sp_we   = 1'b1;
                    sp_wa   = sp_next[3:0];
                    sp_wd   = {dp_reg - 4'd1, hi_reg, p_reg + 7'd1};
                    sp_next = sp_next + 5'd1;
                end
                if (p_reg > lo_reg + 7'd1)
                begin
                    lo_next = lo_reg;
                    hi_next = p_reg;
                    dp_next = dp_reg - 4'd1;
                    st_next = S_DISP;
                end
                else
                    st_next = S_POP;
            end
            // heap build: sift up from i
            S_HUP:
            begin
                if (i_reg >= hn_reg)
                begin
                    i_next  = hn_reg;
                    st_next = S_HDN;
                end
                else
                begin
                    j_next  = i_reg;
                    st_next = S_HUPC;
                end
            end
            S_HUPC:
            begin
                if (j_reg == 7'd0)
                begin
                    i_next  = i_reg + 7'd1;
                    st_next = S_HUP;
                end
                else
                begin
                    a_next  = lo_reg + ((j_reg - 7'd1) >> 1);
                    b_next  = lo_reg + j_reg;
                    j_next  = (j_reg - 7'd1) >> 1;
                    mc_next = 2'd0;
                    ra      = AW'(lo_reg + ((j_reg - 7'd1) >> 1));
                    ret_next = S_HUPC;
                    st_next = S_HCMP;
                end
            end
            // compare a<b, swap if so, else go to ret (or break path)
            S_HCMP:
            begin
                if (mc_reg == 2'd0)
                begin
                    x_next  = rd_reg;
                    ra      = b_reg[AW-1:0];
                    mc_next = 2'd1;
                end
                else if (x_reg < rd_reg)
                begin
                    ra      = a_reg[AW-1:0];
                    st_next = S_RDA;
                end
                else if (ret_reg == S_HDNC)
                    st_next = S_HDN;
                else
                    st_next = ret_reg;
            end
            S_HDN:
            begin
                if (i_reg == 7'd0)
                    st_next = S_POP;
                else
                begin
                    i_next   = i_reg - 7'd1;
                    a_next   = lo_reg;
                    b_next   = lo_reg + i_reg - 7'd1;
                    ra       = lo_reg[AW-1:0];
                    ret_next = S_HDNI;
                    st_next  = S_RDA;
                end
            end
            S_HDNI:
            begin
                p_next  = 7'd0;
                st_next = S_HDNC;
            end
            // sift down: p is the current node, j its first child
            S_HDNC:
            begin
                j_next  = 7'((8'(p_reg) << 1) + 8'd1);
                mc_next = 2'd0;
                if (j_next >= i_reg)
                    st_next = S_HDN;
                else
                begin
                    ra      = AW'(lo_reg + j_next);
                    st_next = S_HSEL;
                end
            end
            // pick the larger child, then compare it with the current node
            S_HSEL:
            begin
                if (mc_reg == 2'd0 && j_reg + 7'd1 < i_reg)
                begin
                    e0_next = rd_reg;
                    mc_next = 2'd1;
                    ra      = AW'(lo_reg + j_reg + 7'd1);
                end
                else
                begin
                    if (mc_reg != 2'd0 && e0_reg < rd_reg)
                        m_next = j_reg + 7'd1;
                    else
                        m_next = j_reg;
                    a_next   = lo_reg + p_reg;
                    b_next   = lo_reg + m_next;
                    p_next   = m_next;
                    ra       = AW'(lo_reg + p_reg);
                    mc_next  = 2'd0;
                    ret_next = S_HDNC;
                    st_next  = S_HCMP;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    ob_next.sorted_value = rd_reg;
                    ob_next.end_of_run   = (k_reg + 7'd1 == n_reg);
                    ob_next.dropped      = (k_reg + 7'd1 == n_reg) && drop_reg;
                    k_next = k_reg + 7'd1;
                    ra     = AW'(k_reg + 7'd1);
                    if (k_reg + 7'd1 >= n_reg)
                        st_next = S_LOAD;
                    else
                        st_next = S_EWAIT;
                end
                else
                    ra = k_reg[AW-1:0];
            end
            S_EWAIT:
            begin
                ra      = k_reg[AW-1:0];
                st_next = S_EMIT;
            end
            default:
                st_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_LOAD;
            sp_reg <= 5'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            sp_reg <= sp_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next; n_reg <= n_next; drop_reg <= drop_next;
        lo_reg <= lo_next; hi_reg <= hi_next; dp_reg <= dp_next;
        i_reg <= i_next; j_reg <= j_next; p_reg <= p_next; k_reg <= k_next;
        a_reg <= a_next; b_reg <= b_next;
        x_reg <= x_next; y_reg <= y_next; v_reg <= v_next;
        mc_reg <= mc_next; m_reg <= m_next; e0_reg <= e0_next; e1_reg <= e1_next;
        hn_reg <= hn_next; ob_reg <= ob_next;
    end

endmodule

// ===== hdl/introsort_engine.sv =====
// Load: one request per cycle into the element memory while the core is loading.
// Sort: each compare and swap goes through the element memory, which has one write
// port and one read port; each result is read, then put in the output register.
// After a last request one more request is taken, then input is held off
// until the final result is in the output register.
// rst_n asynchronously clears counters, state and valid flags; memories are not cleared.
module introsort_engine #(
    parameter int MAX_ITEMS         = 64,
    parameter int SMALL_RANGE_LIMIT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isort_pkg::in_item_t  in_item,
    input  logic                 in_valid,
    output logic                 in_stall,
    output isort_pkg::out_item_t out_item,
    output logic                 out_valid,
    input  logic                 out_stall
);
    import isort_pkg::*;

    cmd_t q_data;
    logic q_valid, q_stall, busy;

    isort_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_item), .in_valid(in_valid), .in_stall(in_stall),
        .q_data(q_data), .q_valid(q_valid), .q_stall(q_stall)
    );

    isort_core #(.MAX_ITEMS(MAX_ITEMS), .SMALL_RANGE_LIMIT(SMALL_RANGE_LIMIT)) u_core (
        .clk(clk), .rst_n(rst_n),
        .q_data(q_data), .q_valid(q_valid), .q_stall(q_stall),
        .out_item(out_item), .out_valid(out_valid), .out_stall(out_stall),
        .busy(busy)
    );

    a_no_out_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_stall) |-> !(out_valid && $past(!busy)))
        else $error("result while loading");

    a_end_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.dropped) |-> out_item.end_of_run)
        else $error("dropped without end_of_run");
endmodule
